// ===== hdl/kwm_pkg.sv =====
// Shared types and constants for the k-way sorted merge block.
// Used by kwm_cell and k_way_sorted_merge; depends on nothing.
`default_nettype none

package kwm_pkg;

   localparam int DATA_W           = 32;
   localparam int RUN_W            = 3;
   localparam int CFG_W            = 4;
   localparam int MAX_RUNS_DEFAULT = 8;
   localparam logic [CFG_W-1:0] RUN_COUNT_RESET = 4'd8;

   // Running minimum handed from cell to cell
   typedef struct packed {
      logic                     any;
      logic                     ready;
      logic signed [DATA_W-1:0] best_val;
      logic [RUN_W-1:0]         best_idx;
   } chain_type;

   // Broadcast from the top level to every cell
   typedef struct packed {
      logic                     fire;
      logic [RUN_W-1:0]         run_index;
      logic signed [DATA_W-1:0] elem_value;
      logic                     is_end;
      logic                     take;
      logic [RUN_W-1:0]         take_idx;
      logic                     clear;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/kwm_cell.sv =====
// One run slot of the merge: head register, valid and exhausted flags,
// and one step of the min-select chain. Depends on kwm_pkg.
`default_nettype none

module kwm_cell #(
   parameter int CELL_ID = 0,
   parameter int CW      = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CW-1:0]    eff_count,
   input  wire kwm_pkg::ctrl_type ctrl,
   input  wire kwm_pkg::chain_type chain_prev,
   output kwm_pkg::chain_type    chain_next
);
   import kwm_pkg::*;

   // Only runs 0..7 can be addressed by a request
   localparam logic            REACHABLE = (CELL_ID < (1 << RUN_W));
   localparam logic [RUN_W-1:0] ID_LO    = RUN_W'(CELL_ID);

   logic signed [DATA_W-1:0] head_ff, head_in;
   logic                     valid_ff, valid_in;
   logic                     exh_ff, exh_in;

   logic active, wr, valid_now, exh_now, taken;
   logic signed [DATA_W-1:0] head_now;

   always_comb begin
      active    = CW'(CELL_ID) < eff_count;
      wr        = ctrl.fire && active && REACHABLE && (ctrl.run_index == ID_LO)
                  && !valid_ff && !exh_ff;
      valid_now = valid_ff | (wr & ~ctrl.is_end);
      exh_now   = exh_ff | (wr & ctrl.is_end);
      head_now  = (wr && !ctrl.is_end) ? ctrl.elem_value : head_ff;
   end

   // Fold this slot into the running minimum; strict less keeps the lower index on ties
   always_comb begin
      chain_next = chain_prev;
      if (active) begin
         if (valid_now) begin
            if (!chain_prev.any || (head_now < chain_prev.best_val)) begin
               chain_next.best_val = head_now;
               chain_next.best_idx = ID_LO;
            end
            chain_next.any = 1'b1;
         end else if (!exh_now) begin
            chain_next.ready = 1'b0;
         end
      end
   end

   always_comb begin
      taken    = ctrl.take && REACHABLE && (ctrl.take_idx == ID_LO);
      head_in  = head_now;
      valid_in = valid_now & ~taken;
      exh_in   = exh_now;
      if (ctrl.clear) begin
         valid_in = 1'b0;
         exh_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         exh_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         exh_ff   <= exh_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/k_way_sorted_merge.sv =====
// Top level of the k-way sorted merge: a row of run cells, the min-select
// chain through them, the run_count register and the result register.
// A request's result sits in the output register in the cycle after accept.
// Throughput: one request per cycle while the output is not stalled; the clock
// is set by the compare chain across MAX_RUNS cells. Reset clears all run flags
// and sets run_count to 8. Depends on kwm_pkg and kwm_cell.
`default_nettype none

module k_way_sorted_merge #(
   parameter int MAX_RUNS = kwm_pkg::MAX_RUNS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [kwm_pkg::RUN_W-1:0]          req_run_index,
   input  wire logic signed [kwm_pkg::DATA_W-1:0]  req_elem_value,
   input  wire logic                               req_is_end,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [kwm_pkg::DATA_W-1:0]       rsp_merged_value,
   output logic [kwm_pkg::RUN_W-1:0]               rsp_refill_run,
   output logic                                    rsp_finished,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [kwm_pkg::CFG_W-1:0]          csr_run_count
);
   import kwm_pkg::*;

   localparam int NW = $clog2(MAX_RUNS + 1);
   localparam int CW = (NW > CFG_W) ? NW : CFG_W;

   logic [CFG_W-1:0]         run_count_ff, run_count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [RUN_W-1:0]         rsp_run_ff, rsp_run_in;
   logic                     rsp_fin_ff, rsp_fin_in;

   logic [CW-1:0] eff_count;
   logic          fire, out_open, emit;
   ctrl_type      ctrl;
   chain_type     chain_w [MAX_RUNS+1];

   assign csr_ready = 1'b1;
   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !out_open;
   assign fire      = req_valid && out_open;

   // Clamp run_count into 1..MAX_RUNS
   always_comb begin
      if (run_count_ff == '0) begin
         eff_count = CW'(1);
      end else if (CW'(run_count_ff) > CW'(MAX_RUNS)) begin
         eff_count = CW'(MAX_RUNS);
      end else begin
         eff_count = CW'(run_count_ff);
      end
   end

   assign chain_w[0] = '{any: 1'b0, ready: 1'b1, best_val: '0, best_idx: '0};

   for (genvar g = 0; g < MAX_RUNS; g++) begin : g_cell
      kwm_cell #(
         .CELL_ID (g),
         .CW      (CW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .eff_count  (eff_count),
         .ctrl       (ctrl),
         .chain_prev (chain_w[g]),
         .chain_next (chain_w[g+1])
      );
   end

   always_comb begin
      emit            = fire && chain_w[MAX_RUNS].ready;
      ctrl.fire       = fire;
      ctrl.run_index  = req_run_index;
      ctrl.elem_value = req_elem_value;
      ctrl.is_end     = req_is_end;
      ctrl.take       = emit && chain_w[MAX_RUNS].any;
      ctrl.take_idx   = chain_w[MAX_RUNS].best_idx;
      ctrl.clear      = emit && !chain_w[MAX_RUNS].any;
   end

   always_comb begin
      run_count_in = (csr_valid && csr_ready) ? csr_run_count : run_count_ff;
   end

   // Hold the result while stalled; otherwise load the new one or drop valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_fin_in   = rsp_fin_ff;
      if (out_open) begin
         rsp_valid_in = emit;
         if (ctrl.take) begin
            rsp_value_in = chain_w[MAX_RUNS].best_val;
            rsp_run_in   = chain_w[MAX_RUNS].best_idx;
            rsp_fin_in   = 1'b0;
         end else begin
            rsp_value_in = '0;
            rsp_run_in   = '0;
            rsp_fin_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff <= RUN_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_count_ff <= run_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_fin_ff   <= rsp_fin_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_refill_run   = rsp_run_ff;
   assign rsp_finished     = rsp_fin_ff;

endmodule

`default_nettype wire

// ===== bench/k_way_sorted_merge_tb.sv =====
// Testbench for k_way_sorted_merge: feeds merge requests and run_count writes, predicts
// every merged result in a scoreboard class and checks what the block delivers.
// Depends on kwm_pkg and the k_way_sorted_merge RTL.

module k_way_sorted_merge_tb;

   localparam int RUNS        = kwm_pkg::MAX_RUNS_DEFAULT;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 138;
   localparam int DIR_ITEMS   = 17;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [kwm_pkg::DATA_W-1:0] merged_value;
      logic [kwm_pkg::RUN_W-1:0]         refill_run;
      logic                              finished;
   } merge_out_t;

   class merge_scoreboard;
      logic signed [kwm_pkg::DATA_W-1:0] head_value [RUNS];
      bit                                head_valid [RUNS];
      bit                                run_done   [RUNS];
      logic [kwm_pkg::CFG_W-1:0]         run_count;
      merge_out_t                        expected_q [$];
      int                                errors;

      function new();
         run_count = kwm_pkg::RUN_COUNT_RESET;
         errors = 0;
         clear_runs();
      endfunction

      function void clear_runs();
         for (int i = 0; i < RUNS; i++) begin
            head_value[i] = '0;
            head_valid[i] = 1'b0;
            run_done[i]   = 1'b0;
         end
      endfunction

      function int live_runs();
         if (run_count == 0) return 1;
         if (run_count > RUNS) return RUNS;
         return int'(run_count);
      endfunction

      // Apply one accepted request; queue and return the result it causes, if any.
      function bit note_request(input logic [kwm_pkg::RUN_W-1:0] run,
                                input logic signed [kwm_pkg::DATA_W-1:0] value,
                                input logic is_end, output merge_out_t res);
         int n;
         int best;
         bit any;
         bit all_set;
         n = live_runs();
         best = 0;
         any = 1'b0;
         all_set = 1'b1;
         res = '0;
         // drop requests for runs outside the merge or already holding a head / ended
         if (run < n && !head_valid[run] && !run_done[run]) begin
            if (is_end) run_done[run] = 1'b1;
            else begin
               head_value[run] = value;
               head_valid[run] = 1'b1;
            end
         end
         for (int i = 0; i < n; i++) begin
            if (head_valid[i]) begin
               if (!any || head_value[i] < head_value[best]) best = i;
               any = 1'b1;
            end else if (!run_done[i]) begin
               all_set = 1'b0;
            end
         end
         if (!all_set) return 1'b0;
         if (any) begin
            res.merged_value = head_value[best];
            res.refill_run   = best[kwm_pkg::RUN_W-1:0];
            head_valid[best] = 1'b0;
         end else begin
            res.finished = 1'b1;
            clear_runs();
         end
         expected_q = {expected_q, res};
         return 1'b1;
      endfunction

      function void check_result(input merge_out_t got);
         merge_out_t want;
         if (expected_q.size() == 0) begin
            $error("unexpected result: merged_value %0d refill_run %0d finished %0b",
                   got.merged_value, got.refill_run, got.finished);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.merged_value !== want.merged_value) begin
            $error("merged_value: expected %0d, got %0d", want.merged_value, got.merged_value);
            errors++;
         end
         if (got.refill_run !== want.refill_run) begin
            $error("refill_run: expected %0d, got %0d", want.refill_run, got.refill_run);
            errors++;
         end
         if (got.finished !== want.finished) begin
            $error("finished: expected %0b, got %0b", want.finished, got.finished);
            errors++;
         end
      endfunction

      function void close();
         if (expected_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_q.size());
            errors++;
         end
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic [kwm_pkg::RUN_W-1:0]          req_run_index;
   logic signed [kwm_pkg::DATA_W-1:0]  req_elem_value;
   logic                               req_is_end;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic signed [kwm_pkg::DATA_W-1:0]  rsp_merged_value;
   logic [kwm_pkg::RUN_W-1:0]          rsp_refill_run;
   logic                               rsp_finished;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [kwm_pkg::CFG_W-1:0]          csr_run_count;

   merge_scoreboard sb;
   int tx_gap_max;
   int rx_gap_max;
   int rx_hold;
   int cycle_count = 0;

   // stimulus state of the well-formed runs
   int                                left_in_run [RUNS];
   logic signed [kwm_pkg::DATA_W-1:0] last_in_run [RUNS];
   bit                                run_started [RUNS];
   int                                refill_q [$];

   // one full merge over all eight runs: extremes, ties, dropped and ended runs
   logic [kwm_pkg::RUN_W-1:0] dir_run [DIR_ITEMS] =
      '{0, 0, 1, 2, 3, 4, 4, 5, 6, 7, 3, 5, 6, 1, 2, 7, 0};
   logic signed [kwm_pkg::DATA_W-1:0] dir_value [DIR_ITEMS] =
      '{32'h7fffffff, 5, 5, 5, 32'h80000000, 32'hffffffff, 7, -1, 0, 5,
        0, 32'h55555555, 0, 32'haaaaaaaa, 0, 0, 0};
   logic dir_end [DIR_ITEMS] =
      '{0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1};
   logic [kwm_pkg::CFG_W-1:0] run_count_plan [PHASES] =
      '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2, 4'd9, 4'd6, 4'd7};

   k_way_sorted_merge dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_run_index    (req_run_index),
      .req_elem_value   (req_elem_value),
      .req_is_end       (req_is_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_value (rsp_merged_value),
      .rsp_refill_run   (rsp_refill_run),
      .rsp_finished     (rsp_finished),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_run_count    (csr_run_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_merged_value, rsp_refill_run, rsp_finished});
   end

   // response side: random stall before each result, or a long hold when asked
   initial begin
      int gap;
      rsp_stall <= 1'b1;
      do @(posedge clock); while (reset);
      forever begin
         if (rx_hold > 0) begin
            gap = rx_hold;
            rx_hold = 0;
         end else begin
            gap = $urandom_range(0, rx_gap_max);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_request(input logic [kwm_pkg::RUN_W-1:0] run,
                               input logic signed [kwm_pkg::DATA_W-1:0] value,
                               input logic is_end, output bit emitted, output merge_out_t res);
      int gap;
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_run_index  <= run;
      req_elem_value <= value;
      req_is_end     <= is_end;
      do @(posedge clock); while (req_stall);
      emitted = sb.note_request(run, value, is_end, res);
   endtask

   // Hold off until every expected result is in, then let the last request settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_run_count(input logic [kwm_pkg::CFG_W-1:0] value);
      csr_valid     <= 1'b1;
      csr_run_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.run_count = value;
   endtask

   // Pick fresh run lengths and queue every run for its first request.
   task automatic start_merge(input int n);
      int j;
      int tmp;
      refill_q.delete();
      for (int i = 0; i < n; i++) begin
         left_in_run[i] = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
         run_started[i] = 1'b0;
         refill_q = {refill_q, i};
      end
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = refill_q[i];
         refill_q[i] = refill_q[j];
         refill_q[j] = tmp;
      end
   endtask

   initial begin
      bit                                emitted;
      merge_out_t                        res;
      int                                n;
      int                                cnt;
      int                                r;
      logic [kwm_pkg::RUN_W-1:0]         run;
      logic signed [kwm_pkg::DATA_W-1:0] value;
      logic                              is_end;
      sb = new();
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_run_index  <= '0;
      req_elem_value <= '0;
      req_is_end     <= 1'b0;
      csr_valid      <= 1'b0;
      csr_run_count  <= '0;
      tx_gap_max = 13;
      rx_gap_max = 13;
      rx_hold = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // run_count still at its reset value here
      for (int i = 0; i < DIR_ITEMS; i++)
         send_request(dir_run[i], dir_value[i], dir_end[i], emitted, res);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         write_run_count(run_count_plan[p]);
         n = sb.live_runs();
         tx_gap_max = (p % 3 == 2) ? 0 : 13;
         rx_gap_max = tx_gap_max;
         start_merge(n);
         cnt = 0;
         while (cnt < PHASE_ITEMS) begin
            // stall the response side long enough for the block to back up
            if (p == 2 && cnt == 40) rx_hold = 80;
            if (refill_q.size() == 0 || $urandom_range(0, 7) == 0) begin
               r      = $urandom_range(0, RUNS - 1);
               run    = r[kwm_pkg::RUN_W-1:0];
               value  = $urandom;
               is_end = ($urandom_range(0, 3) == 0);
            end else begin
               r = refill_q.pop_front();
               run = r[kwm_pkg::RUN_W-1:0];
               is_end = (left_in_run[r] == 0);
               if (is_end)
                  value = $urandom;
               else if (!run_started[r])
                  value = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40) - 20;
               else
                  value = last_in_run[r] + $urandom_range(0, 5);
               if (!is_end) begin
                  last_in_run[r] = value;
                  run_started[r] = 1'b1;
                  left_in_run[r]--;
               end
            end
            send_request(run, value, is_end, emitted, res);
            if (run < n) cnt++;
            if (emitted) begin
               if (res.finished) start_merge(n);
               else refill_q = {refill_q, int'(res.refill_run)};
            end
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      sb.close();
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/kwm_pkg.sv
hdl/kwm_cell.sv
hdl/k_way_sorted_merge.sv
bench/k_way_sorted_merge_tb.sv
